// File: hdl/kbfifo_pkg.sv
// ============================================================================
// kbfifo_pkg
// Shared constants, codes and translation tables for the keyboard code FIFO.
// ============================================================================
package kbfifo_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = 5;
    localparam int CODE_W     = 7;
    localparam int SCAN_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int TABLE_LEN  = 58;
    localparam int TIDX_W     = 6;

    localparam logic [CHAR_W-1:0] CASE_BIT = 7'h20;

    typedef enum logic
    {
        OP_SCAN = 1'b0,
        OP_TAKE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        REG_CTRL_MAKE   = 2'd0,
        REG_LSHIFT_MAKE = 2'd1,
        REG_RSHIFT_MAKE = 2'd2,
        REG_CASE_SWAP   = 2'd3
    } reg_index_t;

    localparam logic [CODE_W-1:0] CTRL_MAKE_RST   = 7'd29;
    localparam logic [CODE_W-1:0] LSHIFT_MAKE_RST = 7'd42;
    localparam logic [CODE_W-1:0] RSHIFT_MAKE_RST = 7'd54;

    typedef logic [CHAR_W-1:0] char_map_t [TABLE_LEN];

    localparam char_map_t PLAIN_MAP = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam char_map_t SHIFTED_MAP = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct packed
    {
        logic valid;
        logic shift;
        logic case_swap;
    } xlate_ctl_t;

endpackage

// File: hdl/kbfifo_code_ram.sv
// ============================================================================
// kbfifo_code_ram
// Code storage of the FIFO: one write port, one read port, registered read.
// ============================================================================
module kbfifo_code_ram
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [kbfifo_pkg::PTR_W-1:0]      wr_addr,
    input  logic [kbfifo_pkg::CODE_W-1:0]     wr_data,
    input  logic                              rd_en,
    input  logic [kbfifo_pkg::PTR_W-1:0]      rd_addr,
    output logic [kbfifo_pkg::CODE_W-1:0]     rd_data
);

    logic [kbfifo_pkg::CODE_W-1:0] mem [kbfifo_pkg::FIFO_DEPTH];
    logic [kbfifo_pkg::CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/kbfifo_xlate.sv
// ============================================================================
// kbfifo_xlate
// Translates a set-1 make code to ASCII, with shift and caps lock applied.
// ============================================================================
module kbfifo_xlate
(
    input  logic [kbfifo_pkg::CODE_W-1:0]  code,
    input  kbfifo_pkg::xlate_ctl_t         ctl,
    output logic [kbfifo_pkg::CHAR_W-1:0]  character
);

    logic [kbfifo_pkg::CHAR_W-1:0] raw;
    logic [kbfifo_pkg::TIDX_W-1:0] idx;
    logic                          in_table;
    logic                          letter;

    always_comb
    begin
        idx      = code[kbfifo_pkg::TIDX_W-1:0];
        in_table = (code < kbfifo_pkg::CODE_W'(kbfifo_pkg::TABLE_LEN));
        raw      = '0;
        if (in_table)
        begin
            raw = ctl.shift ? kbfifo_pkg::SHIFTED_MAP[idx] : kbfifo_pkg::PLAIN_MAP[idx];
        end
        letter = ((raw >= 7'h61) && (raw <= 7'h7A)) || ((raw >= 7'h41) && (raw <= 7'h5A));
        if (!ctl.valid)
        begin
            character = '0;
        end
        else if (ctl.case_swap && letter)
        begin
            character = raw ^ kbfifo_pkg::CASE_BIT;
        end
        else
        begin
            character = raw;
        end
    end

endmodule

// File: hdl/scancode_to_ascii_keyboard_fifo_core.sv
// ============================================================================
// scancode_to_ascii_keyboard_fifo_core
// Keyboard front end: modifier tracking, make-code FIFO and ASCII translation.
// ============================================================================
//  channel | direction | signals
//  --------+-----------+--------------------------------------------------------
//  in      | input     | in_valid, in_ready, opcode, scan_byte
//  out     | output    | out_valid, out_ready, character, char_valid, dropped,
//          |           | shift_held, ctrl_held, fill_level
//  cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// The accept cycle updates pointers and flags and issues the registered code
// RAM read; the second stage translates the read data and loads the output
// register once it is free. Reset clears pointers, fill count, flags and
// valid bits; the code RAM and the output data registers are not cleared.
// A stalled output beat holds one further item in the second stage.
module scancode_to_ascii_keyboard_fifo_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [kbfifo_pkg::SCAN_W-1:0]     scan_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kbfifo_pkg::CHAR_W-1:0]     character,
    output logic                              char_valid,
    output logic                              dropped,
    output logic                              shift_held,
    output logic                              ctrl_held,
    output logic [kbfifo_pkg::FILL_W-1:0]     fill_level,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [kbfifo_pkg::CODE_W-1:0]     cfg_data
);

    logic [kbfifo_pkg::CODE_W-1:0] ctrl_make_reg;
    logic [kbfifo_pkg::CODE_W-1:0] lshift_make_reg;
    logic [kbfifo_pkg::CODE_W-1:0] rshift_make_reg;
    logic                          case_swap_reg;

    logic [kbfifo_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [kbfifo_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [kbfifo_pkg::FILL_W-1:0] occupancy_reg, occupancy_next;
    logic                          shift_flag_reg, shift_flag_next;
    logic                          ctrl_flag_reg, ctrl_flag_next;

    logic                          s2_valid_reg, s2_valid_next;
    logic                          s2_pop_reg, s2_pop_next;
    logic                          s2_drop_reg, s2_drop_next;

    logic                          out_valid_reg;
    logic [kbfifo_pkg::CHAR_W-1:0] character_reg;
    logic                          char_valid_reg;
    logic                          dropped_reg;
    logic                          shift_held_reg;
    logic                          ctrl_held_reg;
    logic [kbfifo_pkg::FILL_W-1:0] fill_level_reg;

    logic                          in_fire;
    logic                          out_load;
    logic                          is_make;
    logic                          fifo_full;
    logic                          push;
    logic                          pop;
    logic [kbfifo_pkg::CODE_W-1:0] rd_code;
    logic [kbfifo_pkg::CHAR_W-1:0] xl_char;
    kbfifo_pkg::xlate_ctl_t        xl_ctl;

    assign in_ready  = !s2_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = s2_valid_reg && (!out_valid_reg || out_ready);

    assign is_make   = (opcode == kbfifo_pkg::OP_SCAN) && !scan_byte[kbfifo_pkg::SCAN_W-1];
    assign fifo_full = (occupancy_reg == kbfifo_pkg::FILL_W'(kbfifo_pkg::FIFO_DEPTH));
    assign push      = in_fire && is_make && !fifo_full;
    assign pop       = in_fire && (opcode == kbfifo_pkg::OP_TAKE) && (occupancy_reg != '0);

    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        occupancy_next  = occupancy_reg;
        shift_flag_next = shift_flag_reg;
        ctrl_flag_next  = ctrl_flag_reg;
        s2_valid_next   = s2_valid_reg;
        s2_pop_next     = s2_pop_reg;
        s2_drop_next    = s2_drop_reg;

        if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            s2_valid_next = 1'b1;
            s2_pop_next   = pop;
            s2_drop_next  = is_make && fifo_full;
            if (opcode == kbfifo_pkg::OP_SCAN)
            begin
                if (scan_byte == {1'b0, ctrl_make_reg})
                begin
                    ctrl_flag_next = 1'b1;
                end
                else if (scan_byte == {1'b1, ctrl_make_reg})
                begin
                    ctrl_flag_next = 1'b0;
                end
                else if ((scan_byte == {1'b0, lshift_make_reg}) ||
                         (scan_byte == {1'b0, rshift_make_reg}))
                begin
                    shift_flag_next = 1'b1;
                end
                else if ((scan_byte == {1'b1, lshift_make_reg}) ||
                         (scan_byte == {1'b1, rshift_make_reg}))
                begin
                    shift_flag_next = 1'b0;
                end
            end
        end

        if (push)
        begin
            if (wr_ptr_reg == kbfifo_pkg::PTR_W'(kbfifo_pkg::FIFO_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + kbfifo_pkg::PTR_W'(1);
            end
            occupancy_next = occupancy_reg + kbfifo_pkg::FILL_W'(1);
        end

        if (pop)
        begin
            if (rd_ptr_reg == kbfifo_pkg::PTR_W'(kbfifo_pkg::FIFO_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + kbfifo_pkg::PTR_W'(1);
            end
            occupancy_next = occupancy_reg - kbfifo_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            occupancy_reg  <= '0;
            shift_flag_reg <= 1'b0;
            ctrl_flag_reg  <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_pop_reg     <= 1'b0;
            s2_drop_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            occupancy_reg  <= occupancy_next;
            shift_flag_reg <= shift_flag_next;
            ctrl_flag_reg  <= ctrl_flag_next;
            s2_valid_reg   <= s2_valid_next;
            s2_pop_reg     <= s2_pop_next;
            s2_drop_reg    <= s2_drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_make_reg   <= kbfifo_pkg::CTRL_MAKE_RST;
            lshift_make_reg <= kbfifo_pkg::LSHIFT_MAKE_RST;
            rshift_make_reg <= kbfifo_pkg::RSHIFT_MAKE_RST;
            case_swap_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (kbfifo_pkg::reg_index_t'(cfg_index))
                kbfifo_pkg::REG_CTRL_MAKE:   ctrl_make_reg   <= cfg_data;
                kbfifo_pkg::REG_LSHIFT_MAKE: lshift_make_reg <= cfg_data;
                kbfifo_pkg::REG_RSHIFT_MAKE: rshift_make_reg <= cfg_data;
                kbfifo_pkg::REG_CASE_SWAP:   case_swap_reg   <= cfg_data[0];
                default:                     case_swap_reg   <= case_swap_reg;
            endcase
        end
    end

    kbfifo_code_ram u_code_ram
    (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (scan_byte[kbfifo_pkg::CODE_W-1:0]),
        .rd_en   (pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_code)
    );

    assign xl_ctl.valid     = s2_pop_reg;
    assign xl_ctl.shift     = shift_flag_reg;
    assign xl_ctl.case_swap = case_swap_reg;

    kbfifo_xlate u_xlate
    (
        .code      (rd_code),
        .ctl       (xl_ctl),
        .character (xl_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            character_reg  <= xl_char;
            char_valid_reg <= s2_pop_reg;
            dropped_reg    <= s2_drop_reg;
            shift_held_reg <= shift_flag_reg;
            ctrl_held_reg  <= ctrl_flag_reg;
            fill_level_reg <= occupancy_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign character  = character_reg;
    assign char_valid = char_valid_reg;
    assign dropped    = dropped_reg;
    assign shift_held = shift_held_reg;
    assign ctrl_held  = ctrl_held_reg;
    assign fill_level = fill_level_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= kbfifo_pkg::FILL_W'(kbfifo_pkg::FIFO_DEPTH))
    else $error("FIFO fill count exceeds the depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (fill_level == kbfifo_pkg::FILL_W'(kbfifo_pkg::FIFO_DEPTH)))
    else $error("A dropped code was reported while the FIFO had room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (occupancy_reg == ($past(occupancy_reg) - kbfifo_pkg::FILL_W'(1))))
    else $error("A pop did not lower the fill count by one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_valid) |-> !dropped)
    else $error("A beat reports both a taken code and a dropped code.");

endmodule

// File: dv/scancode_to_ascii_keyboard_fifo_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// scancode_to_ascii_keyboard_fifo_core_test
// Self-checking bench for the keyboard code FIFO and its ASCII translation.
// Scancode and take beats go in through the input channel, and a scoreboard
// tracks the modifier flags, the code FIFO and the tables. It predicts every
// result beat and compares it field by field. The bench runs under several
// modifier and caps lock settings and under changing idle patterns on both
// sides.
// ============================================================================

typedef struct
{
    logic [kbfifo_pkg::CHAR_W-1:0] character;
    logic                          char_valid;
    logic                          dropped;
    logic                          shift_held;
    logic                          ctrl_held;
    logic [kbfifo_pkg::FILL_W-1:0] fill_level;
} key_result_t;

class keycode_scoreboard;

    // A tab marks a table entry that has no character.
    localparam string PLAIN_KEYS =
        "\t\t1234567890-=\t\tqwertyuiop[]\n\tasdfghjkl;'\140\t\\zxcvbnm,./\t*\t ";
    localparam string SHIFT_KEYS =
        "\t\t!@#$%^&*()_+\t\tQWERTYUIOP{}\n\tASDFGHJKL:\"~\t|ZXCVBNM<>?\t*\t ";

    logic [kbfifo_pkg::CODE_W-1:0] ctrl_code;
    logic [kbfifo_pkg::CODE_W-1:0] lshift_code;
    logic [kbfifo_pkg::CODE_W-1:0] rshift_code;
    bit                            caps_on;

    logic [kbfifo_pkg::CODE_W-1:0] codes [kbfifo_pkg::FIFO_DEPTH];
    int                            rd_ptr;
    int                            wr_ptr;
    int                            occ;
    bit                            shift_on;
    bit                            ctrl_on;

    key_result_t                   expected_keys [$];
    int                            errors;
    int                            n_scans;
    int                            n_takes;
    int                            n_chars;
    int                            n_drops;
    int                            n_empty;

    function new();
        ctrl_code   = kbfifo_pkg::CTRL_MAKE_RST;
        lshift_code = kbfifo_pkg::LSHIFT_MAKE_RST;
        rshift_code = kbfifo_pkg::RSHIFT_MAKE_RST;
        caps_on     = 1'b0;
        rd_ptr      = 0;
        wr_ptr      = 0;
        occ         = 0;
        shift_on    = 1'b0;
        ctrl_on     = 1'b0;
        errors      = 0;
        n_scans     = 0;
        n_takes     = 0;
        n_chars     = 0;
        n_drops     = 0;
        n_empty     = 0;
    endfunction

    function int pending();
        return expected_keys.size();
    endfunction

    function void load_reg(kbfifo_pkg::reg_index_t idx, logic [kbfifo_pkg::CODE_W-1:0] data);
        case (idx)
            kbfifo_pkg::REG_CTRL_MAKE:   ctrl_code = data;
            kbfifo_pkg::REG_LSHIFT_MAKE: lshift_code = data;
            kbfifo_pkg::REG_RSHIFT_MAKE: rshift_code = data;
            kbfifo_pkg::REG_CASE_SWAP:   caps_on = data[0];
            default:                     ;
        endcase
    endfunction

    function logic [kbfifo_pkg::CHAR_W-1:0] to_ascii(logic [kbfifo_pkg::CODE_W-1:0] code);
        byte c;
        if (code >= kbfifo_pkg::TABLE_LEN)
            return '0;
        c = shift_on ? SHIFT_KEYS[code] : PLAIN_KEYS[code];
        if (c == "\t")
            c = 0;
        if (caps_on && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
            c = c ^ kbfifo_pkg::CASE_BIT;
        return c[kbfifo_pkg::CHAR_W-1:0];
    endfunction

    function void take_beat(kbfifo_pkg::opcode_t op, logic [kbfifo_pkg::SCAN_W-1:0] scan);
        key_result_t r;
        r = '{default: '0};
        if (op == kbfifo_pkg::OP_SCAN)
        begin
            n_scans++;
            if (scan == {1'b0, ctrl_code})
                ctrl_on = 1'b1;
            else if (scan == {1'b1, ctrl_code})
                ctrl_on = 1'b0;
            else if (scan == {1'b0, lshift_code} || scan == {1'b0, rshift_code})
                shift_on = 1'b1;
            else if (scan == {1'b1, lshift_code} || scan == {1'b1, rshift_code})
                shift_on = 1'b0;
            if (!scan[kbfifo_pkg::SCAN_W-1])
            begin
                if (occ < kbfifo_pkg::FIFO_DEPTH)
                begin
                    codes[wr_ptr] = scan[kbfifo_pkg::CODE_W-1:0];
                    wr_ptr = (wr_ptr + 1) % kbfifo_pkg::FIFO_DEPTH;
                    occ++;
                end
                else
                begin
                    r.dropped = 1'b1;
                    n_drops++;
                end
            end
        end
        else
        begin
            n_takes++;
            if (occ > 0)
            begin
                r.character  = to_ascii(codes[rd_ptr]);
                r.char_valid = 1'b1;
                rd_ptr = (rd_ptr + 1) % kbfifo_pkg::FIFO_DEPTH;
                occ--;
                if (r.character != 0)
                    n_chars++;
            end
            else
                n_empty++;
        end
        r.shift_held = shift_on;
        r.ctrl_held  = ctrl_on;
        r.fill_level = kbfifo_pkg::FILL_W'(occ);
        expected_keys.push_back(r);
    endfunction

    function void check_beat(key_result_t got);
        key_result_t exp_r;
        if (expected_keys.size() == 0)
        begin
            $error("result beat arrived with no input beat waiting");
            errors++;
            return;
        end
        exp_r = expected_keys.pop_front();
        if (got.character !== exp_r.character)
        begin
            $error("character: expected %0h, got %0h", exp_r.character, got.character);
            errors++;
        end
        if (got.char_valid !== exp_r.char_valid)
        begin
            $error("char_valid: expected %0b, got %0b", exp_r.char_valid, got.char_valid);
            errors++;
        end
        if (got.dropped !== exp_r.dropped)
        begin
            $error("dropped: expected %0b, got %0b", exp_r.dropped, got.dropped);
            errors++;
        end
        if (got.shift_held !== exp_r.shift_held)
        begin
            $error("shift_held: expected %0b, got %0b", exp_r.shift_held, got.shift_held);
            errors++;
        end
        if (got.ctrl_held !== exp_r.ctrl_held)
        begin
            $error("ctrl_held: expected %0b, got %0b", exp_r.ctrl_held, got.ctrl_held);
            errors++;
        end
        if (got.fill_level !== exp_r.fill_level)
        begin
            $error("fill_level: expected %0d, got %0d", exp_r.fill_level, got.fill_level);
            errors++;
        end
    endfunction

endclass

module scancode_to_ascii_keyboard_fifo_core_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 258;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            opcode;
    logic [kbfifo_pkg::SCAN_W-1:0]   scan_byte;
    logic                            out_valid;
    logic                            out_ready;
    logic [kbfifo_pkg::CHAR_W-1:0]   character;
    logic                            char_valid;
    logic                            dropped;
    logic                            shift_held;
    logic                            ctrl_held;
    logic [kbfifo_pkg::FILL_W-1:0]   fill_level;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index;
    logic [kbfifo_pkg::CODE_W-1:0]   cfg_data;

    keycode_scoreboard               sb;
    int                              src_idle;
    int                              dst_idle;
    int                              cycles;
    int                              n_settings;

    scancode_to_ascii_keyboard_fifo_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .scan_byte  (scan_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .char_valid (char_valid),
        .dropped    (dropped),
        .shift_held (shift_held),
        .ctrl_held  (ctrl_held),
        .fill_level (fill_level),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge clk)
    begin : beat_monitor
        key_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.character  = character;
                got.char_valid = char_valid;
                got.dropped    = dropped;
                got.shift_held = shift_held;
                got.ctrl_held  = ctrl_held;
                got.fill_level = fill_level;
                sb.check_beat(got);
            end
            if (in_valid && in_ready)
                sb.take_beat(kbfifo_pkg::opcode_t'(opcode), scan_byte);
            if (cfg_valid && cfg_ready)
                sb.load_reg(kbfifo_pkg::reg_index_t'(cfg_index), cfg_data);
        end
    end

    task automatic send_item(kbfifo_pkg::opcode_t op, logic [kbfifo_pkg::SCAN_W-1:0] scan);
        if ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        scan_byte <= scan;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(kbfifo_pkg::reg_index_t idx, logic [kbfifo_pkg::CODE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(logic [kbfifo_pkg::CODE_W-1:0] ctl,
                             logic [kbfifo_pkg::CODE_W-1:0] ls,
                             logic [kbfifo_pkg::CODE_W-1:0] rs, logic caps);
        wait_drained();
        write_reg(kbfifo_pkg::REG_CTRL_MAKE, ctl);
        write_reg(kbfifo_pkg::REG_LSHIFT_MAKE, ls);
        write_reg(kbfifo_pkg::REG_RSHIFT_MAKE, rs);
        write_reg(kbfifo_pkg::REG_CASE_SWAP, {6'd0, caps});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [kbfifo_pkg::SCAN_W-1:0] pick_scan();
        logic [kbfifo_pkg::CODE_W-1:0] mod;
        case ($urandom_range(2))
            0:       mod = sb.ctrl_code;
            1:       mod = sb.lshift_code;
            default: mod = sb.rshift_code;
        endcase
        case ($urandom_range(9)) inside
            [0:1]:   return {1'b0, mod};
            2:       return {1'b1, mod};
            [3:5]:   return kbfifo_pkg::SCAN_W'($urandom_range(kbfifo_pkg::TABLE_LEN - 1));
            6:       return kbfifo_pkg::SCAN_W'($urandom_range(127, kbfifo_pkg::TABLE_LEN));
            7:       return kbfifo_pkg::SCAN_W'($urandom_range(127));
            default: return kbfifo_pkg::SCAN_W'($urandom_range(255, 128));
        endcase
    endfunction

    // Bursts lean toward filling or draining so the FIFO runs full and empty.
    task automatic run_random(int count);
        int left;
        int burst;
        int scan_pct;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(24, 1);
            case ($urandom_range(2))
                0:       scan_pct = 85;
                1:       scan_pct = 15;
                default: scan_pct = 50;
            endcase
            while (burst > 0 && left > 0)
            begin
                if ($urandom_range(99) < scan_pct)
                    send_item(kbfifo_pkg::OP_SCAN, pick_scan());
                else
                    send_item(kbfifo_pkg::OP_TAKE, kbfifo_pkg::SCAN_W'($urandom_range(255)));
                burst--;
                left--;
            end
            if ($urandom_range(19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb         = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = kbfifo_pkg::OP_SCAN;
        scan_byte  = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = kbfifo_pkg::REG_CTRL_MAKE;
        cfg_data   = '0;
        cycles     = 0;
        n_settings = 1;
        src_idle   = 37;
        dst_idle   = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(kbfifo_pkg::OP_TAKE, 8'hFF);
        send_item(kbfifo_pkg::OP_SCAN, 8'h1E);
        send_item(kbfifo_pkg::OP_SCAN, {1'b0, kbfifo_pkg::LSHIFT_MAKE_RST});
        send_item(kbfifo_pkg::OP_SCAN, 8'h10);
        send_item(kbfifo_pkg::OP_SCAN, {1'b0, kbfifo_pkg::CTRL_MAKE_RST});
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_SCAN, {1'b1, kbfifo_pkg::LSHIFT_MAKE_RST});
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_SCAN, {1'b1, kbfifo_pkg::CTRL_MAKE_RST});
        send_item(kbfifo_pkg::OP_SCAN, 8'h7F);
        send_item(kbfifo_pkg::OP_SCAN, 8'h00);
        send_item(kbfifo_pkg::OP_SCAN, 8'hFF);
        send_item(kbfifo_pkg::OP_SCAN, 8'h80);
        send_item(kbfifo_pkg::OP_SCAN, {1'b0, kbfifo_pkg::RSHIFT_MAKE_RST});
        send_item(kbfifo_pkg::OP_SCAN, 8'h39);
        send_item(kbfifo_pkg::OP_SCAN, {1'b1, kbfifo_pkg::RSHIFT_MAKE_RST});
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        send_item(kbfifo_pkg::OP_TAKE, 8'h00);
        run_random(PHASE_ITEMS);

        src_idle = 71;
        dst_idle = 37;
        configure('0, '1, '1, 1'b1);
        run_random(PHASE_ITEMS);

        src_idle = 0;
        dst_idle = 0;
        configure(kbfifo_pkg::LSHIFT_MAKE_RST, kbfifo_pkg::LSHIFT_MAKE_RST, 7'd57, 1'b0);
        run_random(PHASE_ITEMS);

        configure(kbfifo_pkg::CODE_W'($urandom_range(kbfifo_pkg::TABLE_LEN - 1)),
                  kbfifo_pkg::CODE_W'($urandom_range(kbfifo_pkg::TABLE_LEN - 1)),
                  kbfifo_pkg::CODE_W'($urandom_range(kbfifo_pkg::TABLE_LEN - 1)), 1'b1);
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d scancode and %0d take beats under %0d register settings.",
                 sb.n_scans, sb.n_takes, n_settings);
        $display("Saw %0d characters, %0d full-FIFO drops, %0d takes on an empty FIFO.",
                 sb.n_chars, sb.n_drops, sb.n_empty);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
